[rtl/tcnw_pkg.sv]
package tcnw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int LINE_BYTES = 2 * COLUMNS;
  localparam int SCREEN_BYTES = 2 * COLUMNS * ROWS;

  localparam int CUR_W = 12;
  localparam int COL_W = $clog2(LINE_BYTES);
  localparam int NUM_W = 32;
  localparam int GLYPH_W = 8;
  localparam int ATTR_W = 8;
  localparam int FUNC_W = 3;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;
  localparam int PLACE_W = 36;
  localparam int IDX_W = 4;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [IDX_W-1:0] DEC_LAST_IDX = IDX_W'(9);
  localparam logic [IDX_W-1:0] HEX_LAST_IDX = IDX_W'(7);

  localparam logic [GLYPH_W-1:0] GLYPH_TAB = 8'h09;
  localparam logic [GLYPH_W-1:0] GLYPH_NEWLINE = 8'h0a;
  localparam logic [GLYPH_W-1:0] GLYPH_MINUS = 8'h2d;
  localparam logic [GLYPH_W-1:0] GLYPH_ZERO = 8'h30;
  localparam logic [GLYPH_W-1:0] GLYPH_A = 8'h61;
  localparam logic [GLYPH_W-1:0] GLYPH_X = 8'h78;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CHAR,
    FUNC_UDEC,
    FUNC_SDEC,
    FUNC_HEX,
    FUNC_HEX0X
  } func_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CHAR,
    F_MINUS,
    F_ZERO,
    F_X,
    F_DEC,
    F_HEX
  } front_state_t;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic               last;
  } q_entry_t;

  // k times the decimal weight of digit position idx (position 0 is 10^9)
  function automatic logic [PLACE_W-1:0] dec_multiple(input logic [IDX_W-1:0] idx,
                                                      input int k);
    logic [PLACE_W-1:0] r;
    case (idx)
      4'd0: r = PLACE_W'(k) * 36'd1000000000;
      4'd1: r = PLACE_W'(k) * 36'd100000000;
      4'd2: r = PLACE_W'(k) * 36'd10000000;
      4'd3: r = PLACE_W'(k) * 36'd1000000;
      4'd4: r = PLACE_W'(k) * 36'd100000;
      4'd5: r = PLACE_W'(k) * 36'd10000;
      4'd6: r = PLACE_W'(k) * 36'd1000;
      4'd7: r = PLACE_W'(k) * 36'd100;
      4'd8: r = PLACE_W'(k) * 36'd10;
      default: r = PLACE_W'(k);
    endcase
    return r;
  endfunction

  function automatic logic [GLYPH_W-1:0] hex_char(input logic [3:0] d);
    logic [GLYPH_W-1:0] r;
    if (d <= 4'd9) begin
      r = GLYPH_ZERO + {4'b0, d};
    end else begin
      r = GLYPH_A - 8'd10 + {4'b0, d};
    end
    return r;
  endfunction

endpackage

[rtl/tcnw_queue.sv]
module tcnw_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tcnw_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output tcnw_pkg::q_entry_t head
);
  import tcnw_pkg::*;

  q_entry_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full = (count == (QPTR_W+1)'(QDEPTH));
  assign valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

[rtl/tcnw_front.sv]
module tcnw_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [tcnw_pkg::S_DATA_W-1:0]        s_tdata,
  input  logic [tcnw_pkg::FUNC_W-1:0]          s_tuser,
  input  logic                                 q_full,
  output logic                                 push,
  output tcnw_pkg::q_entry_t                   push_entry
);
  import tcnw_pkg::*;

  front_state_t       state;
  front_state_t       state_next;
  logic [GLYPH_W-1:0] glyph;
  logic [NUM_W-1:0]   value;
  logic [IDX_W-1:0]   idx;
  logic               started;

  logic               accept;
  logic [GLYPH_W-1:0] in_glyph;
  logic [NUM_W-1:0]   in_number;
  logic               in_neg;
  logic [3:0]         dig;
  logic [PLACE_W-1:0] sub;
  logic               emit;
  logic               advance;

  assign in_glyph = s_tdata[GLYPH_W-1:0];
  assign in_number = s_tdata[GLYPH_W +: NUM_W];
  assign in_neg = in_number[NUM_W-1];
  assign accept = s_tvalid && s_tready;

  // one decimal digit per cycle unless a digit waits on a full queue: largest multiple of the place not above value
  always_comb begin
    dig = '0;
    sub = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({{(PLACE_W-NUM_W){1'b0}}, value} >= dec_multiple(idx, k)) begin
        dig = 4'(k);
        sub = dec_multiple(idx, k);
      end
    end
    emit = (dig != '0) || started || (idx == DEC_LAST_IDX);
    advance = !emit || !q_full;
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          case (func_t'(s_tuser))
            FUNC_CHAR: state_next = F_CHAR;
            FUNC_UDEC: state_next = F_DEC;
            FUNC_SDEC: state_next = in_neg ? F_MINUS : F_DEC;
            FUNC_HEX: state_next = F_HEX;
            FUNC_HEX0X: state_next = F_ZERO;
            default: state_next = F_IDLE;
          endcase
        end
      end
      F_CHAR: if (!q_full) state_next = F_IDLE;
      F_MINUS: if (!q_full) state_next = F_DEC;
      F_ZERO: if (!q_full) state_next = F_X;
      F_X: if (!q_full) state_next = F_HEX;
      F_DEC: if (advance && idx == DEC_LAST_IDX) state_next = F_IDLE;
      F_HEX: if (!q_full && idx == HEX_LAST_IDX) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == F_IDLE);
    push = 1'b0;
    push_entry.glyph = '0;
    push_entry.last = 1'b0;
    case (state)
      F_CHAR: begin
        push = !q_full;
        push_entry.glyph = glyph;
        push_entry.last = 1'b1;
      end
      F_MINUS: begin
        push = !q_full;
        push_entry.glyph = GLYPH_MINUS;
      end
      F_ZERO: begin
        push = !q_full;
        push_entry.glyph = GLYPH_ZERO;
      end
      F_X: begin
        push = !q_full;
        push_entry.glyph = GLYPH_X;
      end
      F_DEC: begin
        push = emit && !q_full;
        push_entry.glyph = GLYPH_ZERO + {4'b0, dig};
        push_entry.last = (idx == DEC_LAST_IDX);
      end
      F_HEX: begin
        push = !q_full;
        push_entry.glyph = hex_char(value[NUM_W-1 -: 4]);
        push_entry.last = (idx == HEX_LAST_IDX);
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      glyph <= in_glyph;
      value <= (func_t'(s_tuser) == FUNC_SDEC && in_neg) ? (NUM_W'(0) - in_number)
                                                          : in_number;
      idx <= '0;
      started <= 1'b0;
    end else if (state == F_DEC && advance) begin
      if (emit) begin
        value <= value - sub[NUM_W-1:0];
        started <= 1'b1;
      end
      idx <= idx + 1'b1;
    end else if (state == F_HEX && !q_full) begin
      value <= {value[NUM_W-5:0], 4'b0};
      idx <= idx + 1'b1;
    end
  end

endmodule

[rtl/tcnw_back.sv]
module tcnw_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           text_attribute_we,
  input  logic [tcnw_pkg::ATTR_W-1:0]    text_attribute,
  input  logic                           q_valid,
  input  tcnw_pkg::q_entry_t             q_head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tcnw_pkg::CUR_W-1:0]     out_address,
  output logic [tcnw_pkg::GLYPH_W-1:0]   out_glyph,
  output logic [tcnw_pkg::ATTR_W-1:0]    out_attribute,
  output logic                           out_write,
  output logic [tcnw_pkg::CUR_W-1:0]     out_cursor,
  output logic                           out_last
);
  import tcnw_pkg::*;

  logic [ATTR_W-1:0] attribute;
  logic [CUR_W-1:0]  cursor;
  logic [COL_W-1:0]  col;
  logic [CUR_W-1:0]  cursor_next;
  logic [COL_W-1:0]  col_next;
  logic [CUR_W:0]    cur_sum;
  logic [COL_W:0]    col_sum;
  logic              is_write;

  assign pop = q_valid && (!out_valid || out_ready);

  // col tracks cursor modulo the line length
  always_comb begin
    is_write = 1'b0;
    if (q_head.glyph == GLYPH_NEWLINE) begin
      cur_sum = {1'b0, cursor} - (CUR_W+1)'(col) + (CUR_W+1)'(LINE_BYTES);
      col_sum = '0;
    end else if (q_head.glyph == GLYPH_TAB) begin
      cur_sum = {1'b0, cursor} + (CUR_W+1)'(8);
      col_sum = {1'b0, col} + (COL_W+1)'(8);
    end else begin
      is_write = 1'b1;
      cur_sum = {1'b0, cursor} + (CUR_W+1)'(2);
      col_sum = {1'b0, col} + (COL_W+1)'(2);
    end
    if (col_sum >= (COL_W+1)'(LINE_BYTES)) begin
      col_sum = col_sum - (COL_W+1)'(LINE_BYTES);
    end
    if (cur_sum >= (CUR_W+1)'(SCREEN_BYTES)) begin
      cursor_next = '0;
      col_next = '0;
    end else begin
      cursor_next = cur_sum[CUR_W-1:0];
      col_next = col_sum[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= ATTR_RESET;
      cursor <= '0;
      col <= '0;
      out_valid <= 1'b0;
    end else begin
      if (text_attribute_we) begin
        attribute <= text_attribute;
      end
      if (pop) begin
        cursor <= cursor_next;
        col <= col_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_address <= is_write ? cursor : '0;
      out_glyph <= is_write ? q_head.glyph : '0;
      out_attribute <= is_write ? attribute : '0;
      out_write <= is_write;
      out_cursor <= cursor_next;
      out_last <= q_head.last;
    end
  end

endmodule

[rtl/text_console_number_writer_top.sv]
// channel  | dir | handshake          | payload
// s        | in  | s_tvalid/s_tready  | tdata: glyph_in, number; tuser: func
// m        | out | m_tvalid/m_tready  | tdata: cell_address, glyph_out, attribute_out,
//          |     |                    |        cursor_after; tuser: write_enable; tlast
// cfg      | in  | text_attribute_we  | text_attribute
//
// the front takes an item, then works through each character or digit position in turn:
// char 1, hex 8, hex with 0x 10, decimal 10 (11 when negative)
// it takes no new item until it is done, and an unused func code is accepted with no output
// the decimal converter resolves one digit position per cycle against a constant table,
// except while a digit waits on a full queue; a four-word queue lets the front run ahead
// while the output side is stalled; reset clears the cursor and sets the attribute to 7
module text_console_number_writer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,            // glyph_in[7:0], number[39:8]
  input  logic [2:0]  s_tuser,            // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,            // cell_address[11:0], glyph_out[19:12],
                                          // attribute_out[27:20], cursor_after[39:28]
  output logic        m_tuser,            // write_enable
  output logic        m_tlast,
  input  logic        text_attribute_we,
  input  logic [7:0]  text_attribute
);
  import tcnw_pkg::*;

  logic               push;
  q_entry_t           push_entry;
  logic               q_full;
  logic               pop;
  logic               q_valid;
  q_entry_t           q_head;
  logic [CUR_W-1:0]   out_address;
  logic [GLYPH_W-1:0] out_glyph;
  logic [ATTR_W-1:0]  out_attribute;
  logic [CUR_W-1:0]   out_cursor;

  tcnw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  tcnw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  tcnw_back u_back (
    .clk               (clk),
    .rst               (rst),
    .text_attribute_we (text_attribute_we),
    .text_attribute    (text_attribute),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .pop               (pop),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .out_address       (out_address),
    .out_glyph         (out_glyph),
    .out_attribute     (out_attribute),
    .out_write         (m_tuser),
    .out_cursor        (out_cursor),
    .out_last          (m_tlast)
  );

  assign m_tdata = {out_cursor, out_attribute, out_glyph, out_address};

endmodule

[rtl/tcnw_checker.sv]
module tcnw_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser
);
  import tcnw_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_cursor_even: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[28])
    else $error("cursor odd");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:28] < 12'(SCREEN_BYTES))
    else $error("cursor past screen end");

  a_write_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      (m_tdata[11:0] + 12'd2) == m_tdata[39:28] || m_tdata[39:28] == 12'd0)
    else $error("cell write did not advance cursor by one cell");

endmodule

bind text_console_number_writer_top tcnw_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import tcnw_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
  localparam int unsigned DEC_TOP_PLACE = 32'd1000000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_AT = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 40;

  typedef struct {
    logic [FUNC_W-1:0]  op;
    logic [GLYPH_W-1:0] ch;
    logic [NUM_W-1:0]   num;
  } request_t;

  typedef struct {
    logic [CUR_W-1:0]   addr;
    logic [GLYPH_W-1:0] glyph;
    logic [ATTR_W-1:0]  attr;
    logic               we;
    logic [CUR_W-1:0]   cur;
    logic               last;
  } cell_write_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [39:0]        s_tdata = '0;
  logic [2:0]         s_tuser = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [39:0]        m_tdata;
  logic               m_tuser;
  logic               m_tlast;
  logic               text_attribute_we = 1'b0;
  logic [7:0]         text_attribute = '0;

  request_t    requests[$];
  cell_write_t due_cells[$];
  int          scr_cursor;
  logic [7:0]  scr_attr;
  bit          idle_on;
  int          errors;
  int          items_in;

  text_console_number_writer_top uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .text_attribute_we(text_attribute_we),
    .text_attribute(text_attribute)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int wrap_screen(input int c);
    return (c >= SCREEN_BYTES) ? 0 : c;
  endfunction

  function automatic void put_char(input logic [7:0] g);
    cell_write_t w;
    w.addr = '0;
    w.glyph = '0;
    w.attr = '0;
    w.we = 1'b0;
    w.last = 1'b0;
    if (g == GLYPH_NEWLINE) begin
      scr_cursor = wrap_screen(scr_cursor + LINE_BYTES - scr_cursor % LINE_BYTES);
    end else if (g == GLYPH_TAB) begin
      scr_cursor = wrap_screen(scr_cursor + 8);
    end else begin
      w.addr = CUR_W'(scr_cursor);
      w.glyph = g;
      w.attr = scr_attr;
      w.we = 1'b1;
      scr_cursor = wrap_screen(scr_cursor + 2);
    end
    w.cur = CUR_W'(scr_cursor);
    due_cells.push_back(w);
  endfunction

  function automatic void put_dec(input logic [31:0] v);
    int unsigned val, place, d;
    bit lead;
    val = v;
    place = DEC_TOP_PLACE;
    lead = 1'b0;
    if (val == 0) begin
      put_char(GLYPH_ZERO);
    end else begin
      for (int i = 0; i < 10; i++) begin
        d = val / place;
        if (d != 0 || lead) begin
          lead = 1'b1;
          put_char(GLYPH_ZERO + 8'(d));
          val = val % place;
        end
        place = place / 10;
      end
    end
  endfunction

  function automatic void put_hex(input logic [31:0] v);
    logic [3:0] d;
    for (int i = 7; i >= 0; i--) begin
      d = v[4*i +: 4];
      put_char(d <= 4'd9 ? GLYPH_ZERO + 8'(d) : GLYPH_A + 8'(d) - 8'd10);
    end
  endfunction

  function automatic void print_item(input logic [2:0] op, input logic [7:0] ch,
                                     input logic [31:0] num);
    int n0;
    n0 = due_cells.size();
    case (op)
      FUNC_CHAR: put_char(ch);
      FUNC_UDEC: put_dec(num);
      FUNC_SDEC: begin
        if (num[31]) begin
          put_char(GLYPH_MINUS);
          put_dec(32'd0 - num);
        end else begin
          put_dec(num);
        end
      end
      FUNC_HEX: put_hex(num);
      FUNC_HEX0X: begin
        put_char(GLYPH_ZERO);
        put_char(GLYPH_X);
        put_hex(num);
      end
      default: ;
    endcase
    if (due_cells.size() > n0) due_cells[due_cells.size()-1].last = 1'b1;
  endfunction

  function automatic void add(input logic [2:0] op, input logic [7:0] ch,
                              input logic [31:0] num);
    request_t r;
    r.op = op;
    r.ch = ch;
    r.num = num;
    requests.push_back(r);
  endfunction

  function automatic logic [31:0] rand_number();
    logic [31:0] n;
    case ($urandom_range(0, 3))
      0: n = $urandom;
      1: n = $urandom_range(0, 99);
      2: n = $urandom >> $urandom_range(0, 31);
      default: n = 32'd0 - $urandom_range(0, 1000);
    endcase
    return n;
  endfunction

  // returns 1 when the item produces output
  function automatic bit add_random();
    int sel;
    logic [2:0] op;
    logic [7:0] ch;
    sel = $urandom_range(0, 99);
    ch = 8'($urandom_range(0, 255));
    if (sel < 40) op = FUNC_CHAR;
    else if (sel < 52) op = FUNC_UDEC;
    else if (sel < 64) op = FUNC_SDEC;
    else if (sel < 76) op = FUNC_HEX;
    else if (sel < 92) op = FUNC_HEX0X;
    else op = 3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
    if (op == FUNC_CHAR) begin
      case ($urandom_range(0, 9))
        0, 1, 2: ch = GLYPH_NEWLINE;
        3: ch = GLYPH_TAB;
        default: ;
      endcase
    end
    add(op, ch, rand_number());
    return op < FUNC_SPARE_LO;
  endfunction

  task automatic wait_idle();
    do @(negedge clk); while (requests.size() != 0 || s_tvalid || due_cells.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_attr(input logic [7:0] v);
    @(posedge clk);
    text_attribute_we <= 1'b1;
    text_attribute <= v;
    @(posedge clk);
    text_attribute_we <= 1'b0;
    scr_attr = v;
    @(negedge clk);
  endtask

  task automatic random_phase();
    int n;
    n = 0;
    while (n < PHASE_ITEMS) begin
      if (add_random()) n++;
    end
  endtask

  // sender
  int gap_left;
  always @(posedge clk) begin
    request_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 15) - 1;
        s_tvalid <= 1'b0;
      end else if (requests.size() > 0) begin
        r = requests.pop_front();
        s_tdata <= {r.num, r.ch};
        s_tuser <= r.op;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver, prediction and checking
  int stall_left;
  int hold_left;
  bit held;
  always @(posedge clk) begin
    cell_write_t e;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      held = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        print_item(s_tuser, s_tdata[7:0], s_tdata[39:8]);
        items_in++;
      end
      if (m_tvalid && m_tready) begin
        if (due_cells.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: tdata %h tuser %b tlast %b",
                                     m_tdata, m_tuser, m_tlast);
        end else begin
          e = due_cells.pop_front();
          if (m_tdata[11:0] !== e.addr || m_tdata[19:12] !== e.glyph ||
              m_tdata[27:20] !== e.attr || m_tdata[39:28] !== e.cur ||
              m_tuser !== e.we || m_tlast !== e.last) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: addr %0d/%0d glyph %h/%h attr %h/%h cursor %0d/%0d",
                       e.addr, m_tdata[11:0], e.glyph, m_tdata[19:12],
                       e.attr, m_tdata[27:20], e.cur, m_tdata[39:28]);
              $display("          we %b/%b last %b/%b (expected/actual)",
                       e.we, m_tuser, e.last, m_tlast);
            end
          end
        end
      end
      if (!held && items_in == HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  int quiet;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    scr_cursor = 0;
    scr_attr = ATTR_RESET;
    idle_on = 1'b1;
    errors = 0;
    items_in = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add(FUNC_CHAR, 8'h41, $urandom);
    add(FUNC_CHAR, GLYPH_NEWLINE, $urandom);
    add(FUNC_CHAR, GLYPH_TAB, $urandom);
    add(FUNC_CHAR, 8'h00, 32'hffffffff);
    add(FUNC_CHAR, 8'hff, 32'h0);
    add(FUNC_UDEC, 8'($urandom), 32'd0);
    add(FUNC_UDEC, 8'($urandom), 32'hffffffff);
    add(FUNC_UDEC, 8'($urandom), 32'd1000000000);
    add(FUNC_UDEC, 8'($urandom), 32'd1000000);
    add(FUNC_UDEC, 8'($urandom), 32'd7);
    add(FUNC_SDEC, 8'($urandom), 32'h80000000);
    add(FUNC_SDEC, 8'($urandom), 32'hffffffff);
    add(FUNC_SDEC, 8'($urandom), 32'h7fffffff);
    add(FUNC_SDEC, 8'($urandom), 32'd0);
    add(FUNC_SDEC, 8'($urandom), 32'd12345);
    add(FUNC_HEX, 8'($urandom), 32'h0);
    add(FUNC_HEX, 8'($urandom), 32'hffffffff);
    add(FUNC_HEX, 8'($urandom), 32'h0123abcd);
    add(FUNC_HEX0X, 8'($urandom), 32'hdeadbeef);
    add(FUNC_HEX0X, 8'($urandom), 32'h0);
    add(FUNC_SPARE_LO, 8'($urandom), $urandom);
    add(FUNC_SPARE_LO + 3'd1, 8'($urandom), $urandom);
    add(FUNC_SPARE_HI, 8'($urandom), $urandom);
    add(FUNC_CHAR, GLYPH_NEWLINE, $urandom);
    wait_idle();

    write_attr(8'h00);
    random_phase();
    wait_idle();

    write_attr(8'hff);
    random_phase();
    wait_idle();

    write_attr(8'($urandom_range(1, 254)));
    idle_on = 1'b0;
    random_phase();
    wait_idle();

    errors += due_cells.size();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
